// ===== src/sst_pkg.sv =====
// shared types, codes and lookup tables for the scan code translator
package sst_pkg;

  typedef struct packed {
    logic       operation;
    logic [7:0] scan_byte;
    logic [2:0] lock_bits;
  } in_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] usage_code;
    logic [3:0] media_key;
    logic       pressed;
    logic       led_update;
    logic [2:0] led_bits;
  } out_t;

  // byte class as seen by the back end, independent of prefix and lock state
  typedef struct packed {
    logic       set_locks;
    logic [2:0] lock_bits;
    logic       is_zero;
    logic       is_e0;
    logic       is_e1;
    logic       is_1d;
    logic       is_45;
    logic       make;
    logic [2:0] lock_tog;   // bit0 scroll, bit1 num, bit2 caps
    logic [7:0] plain_usage;
    logic [7:0] ext_usage;
    logic [3:0] media;
  } cls_t;

  localparam logic       OP_SCAN = 1'b0;
  localparam logic       OP_SET  = 1'b1;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_USAGE = 2'd1;
  localparam logic [1:0] EV_MEDIA = 2'd2;

  localparam logic [7:0] BYTE_E0     = 8'hE0;
  localparam logic [7:0] BYTE_E1     = 8'hE1;
  localparam logic [7:0] BYTE_1D     = 8'h1D;
  localparam logic [7:0] BYTE_45     = 8'h45;
  localparam logic [7:0] BYTE_CAPS   = 8'h3A;
  localparam logic [7:0] BYTE_SCROLL = 8'h46;
  localparam logic [7:0] USAGE_PAUSE = 8'h48;

  localparam logic [2:0] LOCKS_RESET = 3'b010;

  localparam logic [7:0] PLAIN_USAGE [128] = '{
    8'h00, 8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
    8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A, 8'h2B,
    8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C,
    8'h12, 8'h13, 8'h2F, 8'h30, 8'h28, 8'hE0, 8'h04, 8'h16,
    8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33,
    8'h34, 8'h35, 8'hE1, 8'h31, 8'h1D, 8'h1B, 8'h06, 8'h19,
    8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'hE5, 8'h55,
    8'hE2, 8'h2C, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
    8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h53, 8'h47, 8'h5F,
    8'h60, 8'h61, 8'h56, 8'h5C, 8'h5D, 8'h5E, 8'h57, 8'h59,
    8'h5A, 8'h5B, 8'h62, 8'h63, 8'h00, 8'h00, 8'h64, 8'h44,
    8'h45, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  function automatic logic [7:0] ext_usage(input logic [6:0] code);
    logic [7:0] u;
    unique case (code)
      7'h1D:   u = 8'hE4;
      7'h38:   u = 8'hE6;
      7'h47:   u = 8'h4A;
      7'h48:   u = 8'h52;
      7'h49:   u = 8'h4B;
      7'h4B:   u = 8'h50;
      7'h4D:   u = 8'h4F;
      7'h4F:   u = 8'h4D;
      7'h50:   u = 8'h51;
      7'h51:   u = 8'h4E;
      7'h52:   u = 8'h49;
      7'h53:   u = 8'h4C;
      7'h1C:   u = 8'h58;
      7'h35:   u = 8'h54;
      7'h37:   u = 8'h46;
      default: u = 8'h00;
    endcase
    return u;
  endfunction

  function automatic logic [3:0] ext_media(input logic [6:0] code);
    logic [3:0] m;
    unique case (code)
      7'h10:   m = 4'd1;
      7'h19:   m = 4'd2;
      7'h22:   m = 4'd3;
      7'h24:   m = 4'd4;
      7'h20:   m = 4'd5;
      7'h30:   m = 4'd6;
      7'h2E:   m = 4'd7;
      7'h5F:   m = 4'd8;
      7'h64:   m = 4'd9;
      default: m = 4'd0;
    endcase
    return m;
  endfunction

endpackage

// ===== src/scan_set1_to_hid_usage.sv =====
// top level of the set 1 scan code to HID usage translator
// Translates keyboard scan code set 1 bytes into HID keyboard usages, media
// key events and lock LED updates, one result item per input item. A byte
// enters the front end, which classifies it and performs all table lookups
// without looking at any state; the classified item then waits in a two-entry
// queue until the back end applies it to the prefix state (none, E0, E1,
// E1 then 1D) and the lock flags and loads the result register. An item can
// be accepted every cycle while the queue has room: the sustained rate is one
// item per clock unless out_ready holds the result register. An accepted
// item is stored in the queue, then in the result register, before it is
// a valid result. in_ready stays high while the queue has room, so the front
// keeps taking items while a finished result still waits to be taken. After
// reset num lock is on, caps and scroll lock are off and no prefix is pending.
module scan_set1_to_hid_usage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sst_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sst_pkg::out_t out_data
);

  sst_pkg::cls_t cls;       // classified input item
  sst_pkg::cls_t q_data;    // head of the queue
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  logic          push;

  // accept whenever the queue has a free slot
  assign in_ready = ~q_full;
  assign push     = in_valid && in_ready;

  // front end: stateless decode and lookups
  sst_front u_front (
    .item (in_data),
    .cls  (cls)
  );

  // decoupling queue
  sst_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  // back end: prefix and lock state plus the result register
  sst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/sst_front.sv =====
// front end: classifies an incoming item and does all table lookups
module sst_front (
  input  sst_pkg::in_t  item,
  output sst_pkg::cls_t cls
);

  logic [6:0] low;
  logic       make;

  assign low  = item.scan_byte[6:0];
  assign make = ~item.scan_byte[7];

  always_comb begin
    cls.set_locks   = (item.operation == sst_pkg::OP_SET);
    cls.lock_bits   = item.lock_bits;
    cls.is_zero     = (item.scan_byte == 8'h00);
    cls.is_e0       = (item.scan_byte == sst_pkg::BYTE_E0);
    cls.is_e1       = (item.scan_byte == sst_pkg::BYTE_E1);
    cls.is_1d       = (item.scan_byte == sst_pkg::BYTE_1D);
    cls.is_45       = (item.scan_byte == sst_pkg::BYTE_45);
    cls.make        = make;
    cls.lock_tog[0] = (item.scan_byte == sst_pkg::BYTE_SCROLL);
    cls.lock_tog[1] = (item.scan_byte == sst_pkg::BYTE_45);
    cls.lock_tog[2] = (item.scan_byte == sst_pkg::BYTE_CAPS);
    cls.plain_usage = sst_pkg::PLAIN_USAGE[low];
    cls.ext_usage   = sst_pkg::ext_usage(low);
    cls.media       = sst_pkg::ext_media(low);
  end

endmodule

// ===== src/sst_fifo.sv =====
// two-entry queue of classified items between front and back end
module sst_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sst_pkg::cls_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output sst_pkg::cls_t pop_data
);

  sst_pkg::cls_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = count_r[1];
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/sst_back.sv =====
// back end: prefix and lock state, result forming and output register
module sst_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  sst_pkg::cls_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output sst_pkg::out_t out_data
);

  localparam logic [1:0] PFX_NONE  = 2'd0;
  localparam logic [1:0] PFX_E0    = 2'd1;
  localparam logic [1:0] PFX_E1    = 2'd2;
  localparam logic [1:0] PFX_E1_1D = 2'd3;

  logic [1:0]    prefix_r, prefix_nxt;
  logic [2:0]    locks_r, locks_nxt;
  logic          out_valid_r, out_valid_nxt;
  sst_pkg::out_t out_data_r, out_data_nxt;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    prefix_nxt   = prefix_r;
    locks_nxt    = locks_r;
    out_data_nxt = '0;
    if (q_data.set_locks) begin
      locks_nxt               = q_data.lock_bits;
      out_data_nxt.led_update = 1'b1;
    end else if (q_data.is_zero) begin
      prefix_nxt = PFX_NONE;
    end else if (q_data.is_e0) begin
      prefix_nxt = PFX_E0;
    end else if (q_data.is_e1) begin
      prefix_nxt = PFX_E1;
    end else begin
      prefix_nxt = PFX_NONE;
      unique case (prefix_r)
        PFX_E0: begin
          if (q_data.ext_usage != 8'h00) begin
            out_data_nxt.event_kind = sst_pkg::EV_USAGE;
            out_data_nxt.usage_code = q_data.ext_usage;
            out_data_nxt.pressed    = q_data.make;
          end else if (q_data.media != 4'd0) begin
            out_data_nxt.event_kind = sst_pkg::EV_MEDIA;
            out_data_nxt.media_key  = q_data.media;
            out_data_nxt.pressed    = q_data.make;
          end
        end
        PFX_E1: begin
          if (q_data.is_1d) begin
            prefix_nxt = PFX_E1_1D;
          end
        end
        PFX_E1_1D: begin
          if (q_data.is_45) begin
            out_data_nxt.event_kind = sst_pkg::EV_USAGE;
            out_data_nxt.usage_code = sst_pkg::USAGE_PAUSE;
            out_data_nxt.pressed    = 1'b1;
          end
        end
        default: begin
          if (q_data.lock_tog != 3'b000) begin
            locks_nxt               = locks_r ^ q_data.lock_tog;
            out_data_nxt.led_update = 1'b1;
          end else if (q_data.plain_usage != 8'h00) begin
            out_data_nxt.event_kind = sst_pkg::EV_USAGE;
            out_data_nxt.usage_code = q_data.plain_usage;
            out_data_nxt.pressed    = q_data.make;
          end
        end
      endcase
    end
    out_data_nxt.led_bits = locks_nxt;
    out_valid_nxt = q_pop || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r    <= PFX_NONE;
      locks_r     <= sst_pkg::LOCKS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        prefix_r <= prefix_nxt;
        locks_r  <= locks_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
